// ===== hdl/jtb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtb_pkg
// Shared types and constants of the JP46 to Bayer reorder / bin unit.
// ----------------------------------------------------------------------------
package jtb_pkg;

  // Macroblock geometry
  localparam int MB_SIZE   = 16;
  localparam int QUAD_SIZE = 8;

  // Window accumulator store
  localparam int SUM_W     = 12;
  localparam int SUM_DEPTH = 2048;
  localparam int IDX_W     = $clog2(SUM_DEPTH);

  // Field widths
  localparam int PIX_W   = 8;
  localparam int POS_W   = 12;
  localparam int CFG_W   = 13;
  localparam int SCALE_W = 2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_SCALE_MODE   = 2'd2
  } jtb_cfg_e;

  // Scale mode codes
  localparam logic [SCALE_W-1:0] SCALE_NONE    = 2'd0;
  localparam logic [SCALE_W-1:0] SCALE_HALF    = 2'd1;
  localparam logic [SCALE_W-1:0] SCALE_QUARTER = 2'd2;
  localparam logic [SCALE_W-1:0] SCALE_ALIAS   = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0]   WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0]   HEIGHT_RST = 13'd480;
  localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_NONE;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;
  } jtb_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_value;
    logic [POS_W-1:0] out_column;
    logic [POS_W-1:0] out_row;
    logic             frame_last;
  } jtb_out_t;

  // Per-pixel control word handed from the position unit to the accumulator
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [SCALE_W-1:0] shift;
    logic               init;
    logic               emit;
    logic [POS_W-1:0]   ocol;
    logic [POS_W-1:0]   orow;
    logic               last;
  } jtb_ctl_t;

  // Map a local macroblock offset back to its mosaic offset
  function automatic logic [3:0] local_map(input logic [3:0] u,
                                           input logic [SCALE_W-1:0] sh);
    logic [2:0] q;
    q = u[2:0] >> sh;
    return {q, 1'b0} + {3'b000, u[3]};
  endfunction

endpackage

// ===== hdl/jtb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module jtb_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/jtb_pos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtb_pos
// Input position counters and macroblock-to-mosaic coordinate mapping.
// ----------------------------------------------------------------------------
module jtb_pos #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic                          frame_start_i,
  input  logic [jtb_pkg::CFG_W-1:0]     frame_width_i,
  input  logic [jtb_pkg::CFG_W-1:0]     frame_height_i,
  input  logic [jtb_pkg::SCALE_W-1:0]   scale_mode_i,
  output jtb_pkg::jtb_ctl_t             ctl_o
);

  localparam int W_AL   = (MAX_WIDTH / jtb_pkg::MB_SIZE) * jtb_pkg::MB_SIZE;
  localparam int H_AL   = (MAX_HEIGHT / jtb_pkg::MB_SIZE) * jtb_pkg::MB_SIZE;
  localparam int W_LIM  = (W_AL < jtb_pkg::MB_SIZE) ? jtb_pkg::MB_SIZE : W_AL;
  localparam int H_LIM  = (H_AL < jtb_pkg::MB_SIZE) ? jtb_pkg::MB_SIZE : H_AL;
  localparam int COL_W  = $clog2(W_LIM);
  localparam int ROW_W  = $clog2(H_LIM);
  localparam int WDIM_W = COL_W + 1;
  localparam int HDIM_W = ROW_W + 1;

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [WDIM_W-1:0] w, c_pre, c_nxt;
  logic [HDIM_W-1:0] h, r_pre, r_nxt;
  logic [jtb_pkg::CFG_W-1:0]   fw_al, fh_al;
  logic [jtb_pkg::SCALE_W-1:0] sh, m;
  logic [COL_W-1:0]  col, col_base;
  logic [ROW_W-1:0]  row, row_base;
  logic [3:0]        u, v;

  // Round dimensions down to whole macroblocks and clamp to the supported range
  always_comb begin
    fw_al = {frame_width_i[jtb_pkg::CFG_W-1:4], 4'b0000};
    fh_al = {frame_height_i[jtb_pkg::CFG_W-1:4], 4'b0000};
    if (fw_al < jtb_pkg::CFG_W'(jtb_pkg::MB_SIZE)) begin
      w = WDIM_W'(jtb_pkg::MB_SIZE);
    end else if (32'(fw_al) > W_LIM) begin
      w = WDIM_W'(W_LIM);
    end else begin
      w = WDIM_W'(fw_al);
    end
    if (fh_al < jtb_pkg::CFG_W'(jtb_pkg::MB_SIZE)) begin
      h = HDIM_W'(jtb_pkg::MB_SIZE);
    end else if (32'(fh_al) > H_LIM) begin
      h = HDIM_W'(H_LIM);
    end else begin
      h = HDIM_W'(fh_al);
    end
  end

  // Normalize the current position, then step to the next one
  always_comb begin
    c_pre = frame_start_i ? '0 : {1'b0, col_q};
    r_pre = frame_start_i ? '0 : {1'b0, row_q};
    if (c_pre >= w) begin
      c_pre = '0;
      r_pre = r_pre + 1'b1;
    end
    if (r_pre >= h) begin
      r_pre = '0;
    end
    col = c_pre[COL_W-1:0];
    row = r_pre[ROW_W-1:0];

    c_nxt = {1'b0, col} + 1'b1;
    r_nxt = {1'b0, row};
    if (c_nxt >= w) begin
      c_nxt = '0;
      r_nxt = r_nxt + 1'b1;
      if (r_nxt >= h) begin
        r_nxt = '0;
      end
    end
    col_d = c_nxt[COL_W-1:0];
    row_d = r_nxt[ROW_W-1:0];
  end

  // Coordinate mapping and window flags
  always_comb begin
    sh       = (scale_mode_i == jtb_pkg::SCALE_ALIAS) ? jtb_pkg::SCALE_QUARTER
                                                      : scale_mode_i;
    m        = jtb_pkg::SCALE_W'((3'd1 << sh) - 3'd1);
    u        = col[3:0];
    v        = row[3:0];
    col_base = (col & ~COL_W'(jtb_pkg::MB_SIZE - 1)) >> sh;
    row_base = (row & ~ROW_W'(jtb_pkg::MB_SIZE - 1)) >> sh;

    ctl_o.idx   = jtb_pkg::IDX_W'(col >> sh);
    ctl_o.shift = sh;
    ctl_o.init  = ((u[1:0] & m) == '0) && ((v[1:0] & m) == '0);
    ctl_o.emit  = ((u[1:0] & m) == m) && ((v[1:0] & m) == m);
    ctl_o.ocol  = jtb_pkg::POS_W'(col_base)
                  + {{(jtb_pkg::POS_W-4){1'b0}}, jtb_pkg::local_map(u, sh)};
    ctl_o.orow  = jtb_pkg::POS_W'(row_base)
                  + {{(jtb_pkg::POS_W-4){1'b0}}, jtb_pkg::local_map(v, sh)};
    ctl_o.last  = ({1'b0, col} == w - 1'b1) && ({1'b0, row} == h - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== hdl/jtb_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtb_acc
// Window accumulator: read-modify-write of the row sum store and result stage.
// ----------------------------------------------------------------------------
module jtb_acc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_fire_i,
  input  logic [jtb_pkg::PIX_W-1:0]   px_i,
  input  jtb_pkg::jtb_ctl_t           ctl_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output jtb_pkg::jtb_out_t           out_data_o
);

  logic                        b_valid_q;
  jtb_pkg::jtb_ctl_t           b_ctl_q;
  logic [jtb_pkg::PIX_W-1:0]   b_px_q;
  logic                        b_hit_q;
  logic [jtb_pkg::SUM_W-1:0]   b_fwd_q;
  logic                        b_adv;
  logic                        b_emit;
  logic [jtb_pkg::SUM_W-1:0]   rdata, b_old, b_sum, b_shifted;
  logic                        ram_we;
  logic                        out_valid_q;
  jtb_pkg::jtb_out_t           out_q, out_d;
  logic                        out_load;

  jtb_ram #(
    .WIDTH (jtb_pkg::SUM_W),
    .DEPTH (jtb_pkg::SUM_DEPTH)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (b_ctl_q.idx),
    .wdata_i (b_sum),
    .re_i    (in_fire_i),
    .raddr_i (ctl_i.idx),
    .rdata_o (rdata)
  );

  always_comb begin
    b_emit    = (b_ctl_q.shift == jtb_pkg::SCALE_NONE) || b_ctl_q.emit;
    b_adv     = b_valid_q && (!b_emit || !out_valid_q || out_ready_i);
    in_ready_o = !b_valid_q || b_adv;
    ram_we    = b_adv && (b_ctl_q.shift != jtb_pkg::SCALE_NONE);
    out_load  = b_adv && b_emit;

    // Take the sum written in the read cycle when it hit the same entry
    b_old     = b_hit_q ? b_fwd_q : rdata;
    b_sum     = b_ctl_q.init ? {{(jtb_pkg::SUM_W-jtb_pkg::PIX_W){1'b0}}, b_px_q}
                             : b_old + {{(jtb_pkg::SUM_W-jtb_pkg::PIX_W){1'b0}}, b_px_q};
    b_shifted = b_sum >> {b_ctl_q.shift, 1'b0};

    out_d.out_value  = (b_ctl_q.shift == jtb_pkg::SCALE_NONE) ? b_px_q
                                                              : b_shifted[jtb_pkg::PIX_W-1:0];
    out_d.out_column = b_ctl_q.ocol;
    out_d.out_row    = b_ctl_q.orow;
    out_d.frame_last = b_ctl_q.last;
  end

  // Stage B payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      b_ctl_q <= ctl_i;
      b_px_q  <= px_i;
      b_hit_q <= ram_we && (b_ctl_q.idx == ctl_i.idx);
      b_fwd_q <= b_sum;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire_i) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // Input back-pressure only comes from an occupied stage B
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (b_valid_q && b_emit && out_valid_q && !out_ready_i))
    else $error("input stalled without cause");

  // A write racing the read of the same entry must be forwarded
  a_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && ram_we && (b_ctl_q.idx == ctl_i.idx)) |=> (b_valid_q && b_hit_q))
    else $error("missed accumulator forward");

  // Stage B leaves no item behind when a new one enters
  a_b_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && b_valid_q) |-> b_adv)
    else $error("stage B item lost");
`endif

endmodule

// ===== hdl/jp46_to_bayer_reorder_bin_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jp46_to_bayer_reorder_bin_unit
// Reorders JP46 macroblock pixels into Bayer mosaic positions, with optional
// 2x2 or 4x4 box downscale through a row accumulator store.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                Payload             Direction
//  -------  -----------------------  ------------------  ---------
//  in       in_valid_i / in_ready_o  in_data_i  (jtb_in_t)   into block
//  out      out_valid_o / out_ready_i out_data_o (jtb_out_t) out of block
//  cfg      cfg_we_i (no wait)       cfg_index_i, cfg_data_i into block
//
//  Throughput: one pixel per cycle unless stalled, bounded by the single
//  read and single write port of the window sum RAM (one read-modify-write
//  per pixel). The RAM read for a taken pixel returns in the cycle after
//  acceptance; the add, write-back and output load then complete as stage
//  B advances, which a waiting result can hold back.
//  Reset: counters, pipeline valids and registers clear at once; the sum
//  store is not cleared (a window's top-left pixel seeds its entry before the rest add to it).
//  Stalls: a waiting result only holds back a pixel that itself emits one
//  (every pixel when unscaled); in_ready_o drops only then.
//
module jp46_to_bayer_reorder_bin_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  jtb_pkg::jtb_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output jtb_pkg::jtb_out_t           out_data_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [jtb_pkg::CFG_W-1:0]   cfg_data_i
);

  logic [jtb_pkg::CFG_W-1:0]   frame_width_q;
  logic [jtb_pkg::CFG_W-1:0]   frame_height_q;
  logic [jtb_pkg::SCALE_W-1:0] scale_mode_q;
  logic                        in_fire;
  jtb_pkg::jtb_ctl_t           ctl;

  // Accept a pixel when both sides agree
  assign in_fire = in_valid_i && in_ready_o;

  // Configuration registers: the user must write them only while the block is idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= jtb_pkg::WIDTH_RST;
      frame_height_q <= jtb_pkg::HEIGHT_RST;
      scale_mode_q   <= jtb_pkg::SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        jtb_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        jtb_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        jtb_pkg::CFG_SCALE_MODE:   scale_mode_q   <= cfg_data_i[jtb_pkg::SCALE_W-1:0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  // Stage A: position counters and coordinate mapping
  jtb_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (in_fire),
    .frame_start_i  (in_data_i.frame_start),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .scale_mode_i   (scale_mode_q),
    .ctl_o          (ctl)
  );

  // Stage B and output register: window sums, averaging, result hand-off
  jtb_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .px_i        (in_data_i.pixel_value),
    .ctl_i       (ctl),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== dv/tb_jp46_to_bayer_reorder_bin_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jp46_to_bayer_reorder_bin_unit
// Self-checking bench for the JP46 to Bayer reorder / bin unit. A scoreboard
// mirrors the macroblock remap and the box-average accumulators, predicts
// every Bayer pixel as its JP46 pixel is taken, and compares the results in
// order. Both handshakes are throttled at random with a long output hold-off.
// ----------------------------------------------------------------------------
module tb_jp46_to_bayer_reorder_bin_unit;
  import jtb_pkg::*;

  localparam int MAX_WIDTH      = 4096;
  localparam int MAX_HEIGHT     = 4096;
  localparam int TOTAL_PIXELS   = 950;  // stop queuing new phases past this
  localparam int DRAIN_CYCLES   = 8;    // covers the two-stage pipe plus margin
  localparam int HOLD_CYCLES    = 250;  // long output hold-off
  localparam int FULL_FRAME_MAX = 32 * 16;  // largest frame a full phase queues

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs (all known from time zero)
  // --------------------------------------------------------------------------
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  jtb_in_t                in_data_i   = '0;
  logic                   out_ready_i = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [1:0]             cfg_index_i = '0;
  logic [CFG_W-1:0]       cfg_data_i  = '0;
  logic                   in_ready_o;
  logic                   out_valid_o;
  jtb_out_t               out_data_o;

  always #1 clk_i = ~clk_i;

  jp46_to_bayer_reorder_bin_unit #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Scoreboard state: register mirror, raster position and window sums
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]   width_reg  = WIDTH_RST;
  logic [CFG_W-1:0]   height_reg = HEIGHT_RST;
  logic [SCALE_W-1:0] scale_reg  = SCALE_RST;
  int                 col_pos    = 0;
  int                 row_pos    = 0;
  logic [SUM_W-1:0]   win_sum [SUM_DEPTH];

  jtb_in_t  jp46_q  [$];   // JP46 pixels waiting for the driver
  jtb_out_t bayer_q [$];   // Bayer pixels expected from the block, oldest first

  int pixels_queued = 0;
  int pixels_taken  = 0;
  int error_cnt     = 0;

  // Throttling state of both channels
  int   tx_gap   = 0;
  int   tx_burst = 0;
  int   rx_gap   = 0;
  int   rx_burst = 0;
  bit   hold_req = 1'b0;
  logic rx_hold  = 1'b0;

  // Round a frame dimension down to whole macroblocks, at least one, capped
  function automatic int fit_dim(input int d, input int max_dim);
    int lim;
    int r;
    lim = max_dim / MB_SIZE * MB_SIZE;
    r   = d / MB_SIZE * MB_SIZE;
    if (lim < MB_SIZE) lim = MB_SIZE;
    if (r < MB_SIZE) r = MB_SIZE;
    if (r > lim) r = lim;
    return r;
  endfunction

  // Offset inside the macroblock -> offset in the mosaic: the quadrant picks
  // the odd/even phase, the position inside the quadrant spreads by two.
  function automatic int mosaic_offset(input int u, input int sh);
    return (((u % QUAD_SIZE) >> sh) * 2) + (u / QUAD_SIZE);
  endfunction

  // Place one taken JP46 pixel; queue a Bayer pixel when one is produced.
  function automatic void reorder_pixel(input jtb_in_t px_in);
    int       w;
    int       h;
    int       sh;
    int       col;
    int       row;
    int       u;
    int       v;
    int       m;
    int       idx;
    logic     emit;
    jtb_out_t res;
    w  = fit_dim(width_reg, MAX_WIDTH);
    h  = fit_dim(height_reg, MAX_HEIGHT);
    sh = (scale_reg == SCALE_ALIAS) ? 2 : int'(scale_reg);

    // Frame start restarts the raster; positions left beyond a shrunken
    // frame fold to the next row, or back to the top.
    if (px_in.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;

    col = col_pos;
    row = row_pos;
    u   = col % MB_SIZE;
    v   = row % MB_SIZE;
    res.out_column = POS_W'(((col / MB_SIZE * MB_SIZE) >> sh) + mosaic_offset(u, sh));
    res.out_row    = POS_W'(((row / MB_SIZE * MB_SIZE) >> sh) + mosaic_offset(v, sh));
    res.frame_last = (col == w - 1) && (row == h - 1);

    // Advance the raster
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end

    emit = 1'b1;
    if (sh == 0) begin
      res.out_value = px_in.pixel_value;
    end else begin
      // Top-left pixel of a window seeds the sum, the rest add (12-bit wrap);
      // the bottom-right pixel releases the truncated average.
      m   = (1 << sh) - 1;
      idx = (col >> sh) % SUM_DEPTH;
      if ((u & m) == 0 && (v & m) == 0) begin
        win_sum[idx] = SUM_W'(px_in.pixel_value);
      end else begin
        win_sum[idx] = win_sum[idx] + SUM_W'(px_in.pixel_value);
      end
      emit          = ((u & m) == m) && ((v & m) == m);
      res.out_value = PIX_W'(win_sum[idx] >> (2 * sh));
    end
    if (emit) bayer_q.push_back(res);
  endfunction

  // Gap before the next transaction: mostly none or short, now and then
  // long, with occasional bursts that run with no gap at all.
  function automatic int draw_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(input string name, input logic [POS_W-1:0] want,
                                      input logic [POS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_cnt++;
    end
  endfunction

  // Compare one Bayer pixel against the oldest expectation
  function automatic void check_result(input jtb_out_t got);
    jtb_out_t want;
    if (bayer_q.size() == 0) begin
      $error("Bayer pixel with none pending: value %0d column %0d row %0d",
             got.out_value, got.out_column, got.out_row);
      error_cnt++;
      return;
    end
    want = bayer_q.pop_front();
    check_field("out_value",  POS_W'(want.out_value),  POS_W'(got.out_value));
    check_field("out_column", want.out_column, got.out_column);
    check_field("out_row",    want.out_row,    got.out_row);
    check_field("frame_last", POS_W'(want.frame_last), POS_W'(got.frame_last));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued pixels; hold valid and payload until the transaction
  // completes, then predict from the pixel that was actually taken.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        reorder_pixel(in_data_i);
        pixels_taken++;
      end
      // Only move on when nothing is on offer or the offer just went through
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (jp46_q.size() > 0) begin
          in_data_i  <= jp46_q.pop_front();
          in_valid_i <= 1'b1;
          tx_gap = draw_gap(tx_burst);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each completed output transaction, throttle ready
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) check_result(out_data_o);
      if (rx_hold) begin
        out_ready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        rx_gap = draw_gap(rx_burst);
      end
    end
  end

  // Long hold-off on the output side: the block backs up and drops in_ready
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Watchdog
  initial begin
    #(2_000_000);
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_pixel(input logic [PIX_W-1:0] px, input logic start);
    jtb_in_t item;
    item.pixel_value = px;
    item.frame_start = start;
    jp46_q.push_back(item);
    pixels_queued++;
  endtask

  // Queue n pixels of random content; optionally open a new frame, and
  // sprinkle stray frame starts at start_pct percent.
  task automatic queue_pixels(input int n, input bit restart, input int start_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      queue_pixel((r == 0) ? 8'h00 : (r == 1) ? 8'hFF : PIX_W'($urandom),
                  (i == 0 && restart) || ($urandom_range(0, 99) < start_pct));
    end
  endtask

  // Wait until every queued pixel is taken and every Bayer pixel is back,
  // then let the pipe flush pixels that produce nothing.
  task automatic wait_drained();
    while (pixels_taken != pixels_queued || bayer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input jtb_cfg_e idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  width_reg = value;
      CFG_FRAME_HEIGHT: height_reg = value;
      CFG_SCALE_MODE:   scale_reg = value[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // Drain, then load a new geometry; scale goes out with junk in the upper bits
  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [SCALE_W-1:0] s);
    logic [CFG_W-1:0] scale_word;
    wait_drained();
    scale_word = CFG_W'($urandom);
    scale_word[SCALE_W-1:0] = s;
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_SCALE_MODE, scale_word);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int                 ph;
    int                 kind;
    bit                 full;
    logic [CFG_W-1:0]   w;
    logic [CFG_W-1:0]   h;
    logic [SCALE_W-1:0] scl;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry (640x480, no scaling), extreme pixels, restart mid-frame
    queue_pixel(8'h00, 1'b1);
    queue_pixel(8'hFF, 1'b0);
    queue_pixel(8'hAA, 1'b1);
    queue_pixel(8'h55, 1'b0);

    // Oversized width clips to the cap, zero height rises to one macroblock;
    // walk across the quadrant seam.
    set_geometry(13'h1FFF, 13'h0000, SCALE_NONE);
    queue_pixels(10, 1'b1, 0);

    // Unaligned dimensions round down to 16x16; first 2x2 window of all ones
    set_geometry(13'd31, 13'd17, SCALE_HALF);
    queue_pixel(8'hFF, 1'b1);
    for (int i = 0; i < 17; i++) queue_pixel(8'hFF, 1'b0);

    // Clean 2x2 pass over one band at width 64: seeds the low sum entries
    // so that later mid-frame geometry changes only add to written entries.
    set_geometry(13'd64, 13'd16, SCALE_HALF);
    queue_pixels(128, 1'b1, 0);

    // Back-pressure: hold the output long enough to stall the input, then
    // pause the sender until every Bayer pixel is back, then resume the frame.
    set_geometry(13'd32, 13'd32, SCALE_NONE);
    queue_pixels(40, 1'b1, 0);
    hold_req = 1'b1;
    queue_pixels(100, 1'b0, 0);
    wait_drained();
    queue_pixels(60, 1'b0, 0);

    // Random phases. Wide frames always open with a frame start; narrow ones
    // (64 or less) may carry on mid-frame across a geometry change.
    ph = 0;
    while (pixels_queued < TOTAL_PIXELS) begin
      kind = (ph == 0) ? 0 : $urandom_range(0, 9);
      scl  = SCALE_W'($urandom_range(0, 3));
      if (kind == 0) begin
        case ($urandom_range(0, 2))
          0:       w = 13'h1FFF;
          1:       w = 13'd4096;
          default: w = CFG_W'($urandom_range(65, 8191));
        endcase
        h = CFG_W'($urandom_range(0, 8191));
        set_geometry(w, h, scl);
        queue_pixels($urandom_range(30, 80), 1'b1, 2);
      end else begin
        // Keep whole-frame phases inside the pixel budget
        full = ($urandom_range(0, 3) == 0) &&
               (pixels_queued + FULL_FRAME_MAX <= TOTAL_PIXELS);
        if (full) begin
          w = CFG_W'($urandom_range(0, 47));
          h = CFG_W'($urandom_range(0, 31));
        end else begin
          w = CFG_W'($urandom_range(0, 79));
          h = CFG_W'($urandom_range(0, 79));
        end
        set_geometry(w, h, scl);
        if (full) begin
          queue_pixels(fit_dim(w, MAX_WIDTH) * fit_dim(h, MAX_HEIGHT), 1'b1, 0);
        end else begin
          queue_pixels($urandom_range(10, 120), $urandom_range(0, 99) < 60, 2);
        end
      end
      ph++;
    end

    wait_drained();
    if (error_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
